### design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on clk and held off during reset
`define PMQ_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk and held off during reset
`define PMQ_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/pmq_pkg.sv
`default_nettype none

package pmq_pkg;

	localparam int MAX_ENTRIES_DEF = 256;
	localparam int TAG_BITS_DEF    = 16;

	localparam int LEN_W    = 21;
	localparam int PRIO_W   = 15;
	localparam int TAG_W    = 16;
	localparam int COUNT_W  = 9;
	localparam int STATUS_W = 3;
	localparam int REQ_W    = 2;
	localparam int MAXMSG_W = 9;
	localparam int CFG_IDX_W = 1;

	localparam logic [MAXMSG_W-1:0] MAX_MESSAGES_RST = 9'd10;
	localparam logic [LEN_W-1:0]    SIZE_LIMIT_RST   = 21'd8192;

	typedef enum logic [REQ_W-1:0] {
		REQ_SEND  = 2'd0,
		REQ_RECV  = 2'd1,
		REQ_QUERY = 2'd2
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_TOO_LONG  = 3'd1,
		ST_FULL      = 3'd2,
		ST_EMPTY     = 3'd3,
		ST_SMALL_BUF = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAX_MESSAGES = 1'b0,
		CFG_SIZE_LIMIT   = 1'b1
	} cfg_idx_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic              push;
		logic              pop;
		logic [LEN_W-1:0]  len;
		logic [PRIO_W-1:0] prio;
	} cell_ctl_t;

endpackage

`default_nettype wire

### design/pmq_cell.sv
`default_nettype none

module pmq_cell
	import pmq_pkg::*;
#(
	parameter int TAG_BITS = TAG_BITS_DEF
) (
	input  wire logic                clk,
	input  wire cell_ctl_t           ctl,
	input  wire logic [TAG_BITS-1:0] new_tag,
	input  wire logic                occ,
	input  wire logic                prev_ge,
	input  wire logic [LEN_W-1:0]    prev_len,
	input  wire logic [PRIO_W-1:0]   prev_prio,
	input  wire logic [TAG_BITS-1:0] prev_tag,
	input  wire logic [LEN_W-1:0]    next_len,
	input  wire logic [PRIO_W-1:0]   next_prio,
	input  wire logic [TAG_BITS-1:0] next_tag,
	output logic                     ge,
	output logic [LEN_W-1:0]         len,
	output logic [PRIO_W-1:0]        prio,
	output logic [TAG_BITS-1:0]      tag
);

	logic [LEN_W-1:0]    len_q;
	logic [PRIO_W-1:0]   prio_q;
	logic [TAG_BITS-1:0] tag_q;

	// held entry stays ahead of the new one on equal priority
	assign ge   = occ && (prio_q >= ctl.prio);
	assign len  = len_q;
	assign prio = prio_q;
	assign tag  = tag_q;

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			if (!ge) begin
				if (prev_ge) begin
					len_q  <= ctl.len;
					prio_q <= ctl.prio;
					tag_q  <= new_tag;
				end else begin
					len_q  <= prev_len;
					prio_q <= prev_prio;
					tag_q  <= prev_tag;
				end
			end
		end else if (ctl.pop) begin
			len_q  <= next_len;
			prio_q <= next_prio;
			tag_q  <= next_tag;
		end
	end

endmodule

`default_nettype wire

### design/priority_message_queue_unit.sv
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  tuser: req_type; tdata: msg_length, msg_priority, payload_tag
// m_*      out  m_tvalid/m_tready  tuser: status; tdata: out_length, out_priority, out_tag,
//                                  current_count
// cfg_*    in   cfg_we             cfg_index selects register, cfg_data is the value
//
// one request per cycle while m_* is not stalled; its result shows on m_* in the cycle after the transfer
// a send or receive is done in the cell row in the transfer cycle itself: every cell compares
// its priority against the new one and shifts, loads or holds at once
// reset empties the queue and loads max_messages 10 and message_size_limit 8192
// s_tready stays high while the output register is empty or being taken, so a stall on
// m_* holds one result and then back-pressures s_*
`default_nettype none

`include "assert_macros.svh"

module priority_message_queue_unit
	import pmq_pkg::*;
#(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
	parameter int TAG_BITS    = TAG_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [55:0]          s_tdata,   // msg_length, msg_priority, payload_tag, zero pad
	input  wire logic [REQ_W-1:0]     s_tuser,   // req_type
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [63:0]               m_tdata,   // out_length, out_priority, out_tag,
	                                             // current_count, zero pad
	output logic [STATUS_W-1:0]       m_tuser,   // status
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [LEN_W-1:0]     cfg_data
);

	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W = (CNT_W > MAXMSG_W) ? CNT_W : MAXMSG_W;

	logic [MAXMSG_W-1:0] max_msg_q;
	logic [LEN_W-1:0]    size_lim_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    count_nxt;

	logic                out_valid_q;
	status_t             out_status_q;
	logic [LEN_W-1:0]    out_len_q;
	logic [PRIO_W-1:0]   out_prio_q;
	logic [TAG_W-1:0]    out_tag_q;
	logic [COUNT_W-1:0]  out_count_q;

	logic                accept;
	req_t                req;
	logic [LEN_W-1:0]    in_len;
	logic [PRIO_W-1:0]   in_prio;
	logic [TAG_BITS-1:0] in_tag;
	logic                full;
	status_t             status_nxt;
	cell_ctl_t           ctl;

	// chain index k holds cell k-1; index 0 carries the new entry, the last is the end stop
	logic                ge_chain   [MAX_ENTRIES+1];
	logic [LEN_W-1:0]    len_chain  [MAX_ENTRIES+2];
	logic [PRIO_W-1:0]   prio_chain [MAX_ENTRIES+2];
	logic [TAG_BITS-1:0] tag_chain  [MAX_ENTRIES+2];

	assign req     = req_t'(s_tuser);
	assign in_len  = s_tdata[20:0];
	assign in_prio = s_tdata[35:21];
	assign in_tag  = TAG_BITS'(s_tdata[51:36]);

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign full = (CMP_W'(count_q) >= CMP_W'(max_msg_q)) ||
		(count_q == CNT_W'(MAX_ENTRIES));

	always_comb begin
		status_nxt = ST_OK;
		ctl.push   = 1'b0;
		ctl.pop    = 1'b0;
		ctl.len    = in_len;
		ctl.prio   = in_prio;
		unique case (req)
			REQ_SEND: begin
				if (in_len > size_lim_q) begin
					status_nxt = ST_TOO_LONG;
				end else if (full) begin
					status_nxt = ST_FULL;
				end else begin
					ctl.push = accept;
				end
			end
			REQ_RECV: begin
				if (count_q == '0) begin
					status_nxt = ST_EMPTY;
				end else if (in_len < size_lim_q && in_len < len_chain[1]) begin
					status_nxt = ST_SMALL_BUF;
				end else begin
					ctl.pop = accept;
				end
			end
			default: begin
				status_nxt = ST_OK;
			end
		endcase
	end

	always_comb begin
		count_nxt = count_q;
		if (ctl.push) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (ctl.pop) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	assign ge_chain[0]               = 1'b1;
	assign len_chain[0]              = in_len;
	assign prio_chain[0]             = in_prio;
	assign tag_chain[0]              = in_tag;
	assign len_chain[MAX_ENTRIES+1]  = '0;
	assign prio_chain[MAX_ENTRIES+1] = '0;
	assign tag_chain[MAX_ENTRIES+1]  = '0;

	for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
		pmq_cell #(
			.TAG_BITS (TAG_BITS)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.new_tag   (in_tag),
			.occ       (CNT_W'(g) < count_q),
			.prev_ge   (ge_chain[g]),
			.prev_len  (len_chain[g]),
			.prev_prio (prio_chain[g]),
			.prev_tag  (tag_chain[g]),
			.next_len  (len_chain[g+2]),
			.next_prio (prio_chain[g+2]),
			.next_tag  (tag_chain[g+2]),
			.ge        (ge_chain[g+1]),
			.len       (len_chain[g+1]),
			.prio      (prio_chain[g+1]),
			.tag       (tag_chain[g+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_msg_q  <= MAX_MESSAGES_RST;
			size_lim_q <= SIZE_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_MAX_MESSAGES: max_msg_q  <= cfg_data[MAXMSG_W-1:0];
				CFG_SIZE_LIMIT:   size_lim_q <= cfg_data;
				default:          max_msg_q  <= max_msg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_nxt;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_status_q <= status_nxt;
			out_count_q  <= COUNT_W'(count_nxt);
			if (ctl.pop) begin
				out_len_q  <= len_chain[1];
				out_prio_q <= prio_chain[1];
				out_tag_q  <= TAG_W'(tag_chain[1]);
			end else begin
				out_len_q  <= '0;
				out_prio_q <= '0;
				out_tag_q  <= '0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {3'b000, out_count_q, out_tag_q, out_prio_q, out_len_q};

	`PMQ_ASSERT_NXT(a_push_count, ctl.push, count_q == $past(count_q) + CNT_W'(1), "push must raise the count by one")
	`PMQ_ASSERT_NXT(a_pop_count, ctl.pop, count_q == $past(count_q) - CNT_W'(1), "pop must lower the count by one")
	`PMQ_ASSERT_IMP(a_push_room, ctl.push, count_q < CNT_W'(MAX_ENTRIES), "push into a full cell row")
	`PMQ_ASSERT_IMP(a_pop_held, ctl.pop, (count_q != '0) && !ctl.push, "pop from an empty row or with a push")

endmodule

`default_nettype wire
